>>> hdl/tfrc_pkg.sv
// shared types, constants and band tables for the tone frequency reload calculator
package tfrc_pkg;

   // field widths
   localparam int FREQ_W   = 11;
   localparam int STEP_W   = 8;
   localparam int OFF_W    = 8;
   localparam int RELOAD_W = 16;
   localparam int PRE_W    = 2;
   localparam int MULT_W   = 4;

   // divider: 21-bit dividend, one quotient bit per cycle
   localparam int DIVD_W = 21;
   localparam int REM_W  = FREQ_W;
   localparam int CNT_W  = 5;
   localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIVD_W);

   // frequency limits and band edges
   localparam logic [FREQ_W-1:0] UPPER_FREQ_LIMIT = 11'd1000;
   localparam logic [FREQ_W-1:0] FREQ_MIN         = 11'd1;
   localparam logic [FREQ_W-1:0] FREQ_MAX         = 11'd1254;
   localparam logic [FREQ_W-1:0] EDGE_TOP         = 11'd100;
   localparam logic [FREQ_W-1:0] EDGE_HIGH        = 11'd60;
   localparam logic [FREQ_W-1:0] EDGE_MID         = 11'd30;
   localparam logic [FREQ_W-1:0] EDGE_LOW         = 11'd20;

   // reset values
   localparam logic [FREQ_W-1:0]   FREQ_RESET   = 11'd1000;
   localparam logic [RELOAD_W-1:0] RELOAD_RESET = 16'hFF00;
   localparam logic [OFF_W-1:0]    OFFSET_RESET = 8'd32;

   // prescaler codes and extension multipliers
   localparam logic [PRE_W-1:0]  PRE_DIV1  = 2'd0;
   localparam logic [PRE_W-1:0]  PRE_DIV2  = 2'd1;
   localparam logic [PRE_W-1:0]  PRE_DIV4  = 2'd2;
   localparam logic [PRE_W-1:0]  PRE_DIV8  = 2'd3;
   localparam logic [MULT_W-1:0] MULT_NONE = 4'd0;
   localparam logic [MULT_W-1:0] MULT_SUB  = 4'd12;

   // frequency bands, highest first
   typedef enum logic [2:0] {
      BAND_TOP,
      BAND_HIGH,
      BAND_MID,
      BAND_LOW,
      BAND_SUB
   } band_type;

   // microcode: datapath operation of one step
   typedef enum logic [2:0] {
      ALU_NOP,
      ALU_STEP_FREQ,
      ALU_DIV_LOAD,
      ALU_DIV_STEP,
      ALU_SUB_OFF,
      ALU_TIMES3,
      ALU_RELOAD,
      ALU_PUBLISH
   } alu_type;

   // microcode: jump condition
   typedef enum logic [2:0] {
      COND_NONE,
      COND_NO_ITEM,
      COND_BLOCKED,
      COND_DIV_BUSY,
      COND_OUT_BUSY
   } cond_type;

   localparam int PC_W = 3;
   localparam logic [PC_W-1:0] ADDR_WAIT    = 3'd0;
   localparam logic [PC_W-1:0] ADDR_STEP    = 3'd1;
   localparam logic [PC_W-1:0] ADDR_LOAD    = 3'd2;
   localparam logic [PC_W-1:0] ADDR_DIV     = 3'd3;
   localparam logic [PC_W-1:0] ADDR_SUB     = 3'd4;
   localparam logic [PC_W-1:0] ADDR_TIMES3  = 3'd5;
   localparam logic [PC_W-1:0] ADDR_RELOAD  = 3'd6;
   localparam logic [PC_W-1:0] ADDR_PUBLISH = 3'd7;

   typedef struct packed {
      logic            accept;
      cond_type        cond;
      logic [PC_W-1:0] target;
      alu_type         alu;
   } ctrl_type;

   typedef struct packed {
      logic item_valid;
      logic blocked;
      logic div_busy;
      logic out_busy;
   } status_type;

   // band of a frequency
   function automatic band_type band_of(input logic [FREQ_W-1:0] f);
      band_type b;
      if (f > EDGE_TOP)       b = BAND_TOP;
      else if (f > EDGE_HIGH) b = BAND_HIGH;
      else if (f > EDGE_MID)  b = BAND_MID;
      else if (f > EDGE_LOW)  b = BAND_LOW;
      else                    b = BAND_SUB;
      return b;
   endfunction

   // half-period dividend of a band
   function automatic logic [DIVD_W-1:0] band_dividend(input band_type b);
      logic [DIVD_W-1:0] d;
      unique case (b)
         BAND_TOP:  d = 21'd2000000;
         BAND_HIGH: d = 21'd1000000;
         BAND_MID:  d = 21'd500000;
         BAND_LOW:  d = 21'd250000;
         default:   d = 21'd62500;
      endcase
      return d;
   endfunction

   function automatic logic [PRE_W-1:0] band_prescale(input band_type b);
      logic [PRE_W-1:0] p;
      unique case (b)
         BAND_TOP:  p = PRE_DIV1;
         BAND_HIGH: p = PRE_DIV2;
         BAND_MID:  p = PRE_DIV4;
         default:   p = PRE_DIV8;
      endcase
      return p;
   endfunction

endpackage

>>> hdl/tfrc_useq.sv
// microcode sequencer: step counter, control store and conditional jumps
module tfrc_useq
   import tfrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctrl_type   ctrl
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            take_jump;

   // control store
   always_comb begin
      unique case (pc_ff)
         ADDR_WAIT:    ctrl = '{1'b1, COND_NO_ITEM,  ADDR_WAIT,    ALU_NOP};
         ADDR_STEP:    ctrl = '{1'b0, COND_BLOCKED,  ADDR_PUBLISH, ALU_STEP_FREQ};
         ADDR_LOAD:    ctrl = '{1'b0, COND_NONE,     ADDR_WAIT,    ALU_DIV_LOAD};
         ADDR_DIV:     ctrl = '{1'b0, COND_DIV_BUSY, ADDR_DIV,     ALU_DIV_STEP};
         ADDR_SUB:     ctrl = '{1'b0, COND_NONE,     ADDR_WAIT,    ALU_SUB_OFF};
         ADDR_TIMES3:  ctrl = '{1'b0, COND_NONE,     ADDR_WAIT,    ALU_TIMES3};
         ADDR_RELOAD:  ctrl = '{1'b0, COND_NONE,     ADDR_WAIT,    ALU_RELOAD};
         // falls through to the wait step by counter wrap
         ADDR_PUBLISH: ctrl = '{1'b0, COND_OUT_BUSY, ADDR_PUBLISH, ALU_PUBLISH};
         default:      ctrl = '{1'b0, COND_NONE,     ADDR_WAIT,    ALU_NOP};
      endcase
   end

   // jump condition select
   always_comb begin
      unique case (ctrl.cond)
         COND_NO_ITEM:  take_jump = !status.item_valid;
         COND_BLOCKED:  take_jump = status.blocked;
         COND_DIV_BUSY: take_jump = status.div_busy;
         COND_OUT_BUSY: take_jump = status.out_busy;
         default:       take_jump = 1'b0;
      endcase
   end

   assign pc_in = take_jump ? ctrl.target : pc_ff + PC_W'(1);

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ADDR_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> hdl/tone_frequency_reload_calculator.sv
// top level: handshake, microcoded datapath and result register of the tone reload calculator
// an unblocked beat runs the steps wait, step, load, bit-serial half-period divide, subtract
//   offset, times three, reload and publish; a blocked beat goes from step straight to publish
// a new beat is taken only after the previous one is published
// a new beat is taken while the previous result still waits on the rsp side
// reset (synchronous): frequency 1000, reload 0xFF00, prescaler 1:1, multiplier 0, offset 32
module tone_frequency_reload_calculator
   import tfrc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [OFF_W-1:0]    csr_write_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic [STEP_W-1:0]   req_step_size,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [RELOAD_W-1:0] rsp_reload_value,
   output logic [PRE_W-1:0]    rsp_prescale_code,
   output logic [MULT_W-1:0]   rsp_extend_multiplier,
   output logic [FREQ_W-1:0]   rsp_current_frequency,
   output logic                rsp_was_updated
);

   ctrl_type   ctrl;
   status_type status;

   // control state
   logic [OFF_W-1:0]    offset_ff,  offset_in;
   logic [FREQ_W-1:0]   freq_ff,    freq_in;
   logic [RELOAD_W-1:0] reload_ff,  reload_in;
   logic [PRE_W-1:0]    pre_ff,     pre_in;
   logic [MULT_W-1:0]   mult_ff,    mult_in;
   logic                updated_ff, updated_in;
   logic                valid_ff,   valid_in;

   // payload registers
   logic                op_ff,   op_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   band_type            band_ff, band_in;
   logic [CNT_W-1:0]    cnt_ff,  cnt_in;
   logic [REM_W-1:0]    rem_ff,  rem_in;
   logic [DIVD_W-1:0]   quo_ff,  quo_in;
   logic [RELOAD_W-1:0] acc_ff,  acc_in;
   logic [RELOAD_W-1:0] out_reload_ff, out_reload_in;
   logic [PRE_W-1:0]    out_pre_ff,    out_pre_in;
   logic [MULT_W-1:0]   out_mult_ff,   out_mult_in;
   logic [FREQ_W-1:0]   out_freq_ff,   out_freq_in;
   logic                out_upd_ff,    out_upd_in;

   logic                accept;
   logic                allowed;
   logic                publish;
   logic [FREQ_W-1:0]   divisor;
   logic [REM_W:0]      trial;
   logic [REM_W:0]      diff;
   logic                ge;
   logic [FREQ_W-1:0]   step_ext;

   tfrc_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // handshake and status for the sequencer
   assign req_ready = ctrl.accept;
   assign accept    = req_valid && ctrl.accept;
   assign step_ext  = FREQ_W'(step_ff);
   assign allowed   = op_ff ? (freq_ff < UPPER_FREQ_LIMIT) : (freq_ff > FREQ_MIN);

   assign status.item_valid = req_valid;
   assign status.blocked    = !allowed;
   assign status.div_busy   = (cnt_ff != CNT_W'(1));
   assign status.out_busy   = valid_ff && !rsp_ready;

   assign publish = (ctrl.alu == ALU_PUBLISH) && !status.out_busy;

   // divider step, divisor never zero in practice
   assign divisor = (freq_ff == '0) ? FREQ_MIN : freq_ff;
   assign trial   = {rem_ff, quo_ff[DIVD_W-1]};
   assign diff    = trial - {1'b0, divisor};
   assign ge      = (trial >= {1'b0, divisor});

   // datapath
   always_comb begin
      offset_in     = csr_write_en ? csr_write_data : offset_ff;
      op_in         = accept ? req_opcode : op_ff;
      step_in       = accept ? req_step_size : step_ff;
      freq_in       = freq_ff;
      reload_in     = reload_ff;
      pre_in        = pre_ff;
      mult_in       = mult_ff;
      updated_in    = updated_ff;
      band_in       = band_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      acc_in        = acc_ff;
      out_reload_in = out_reload_ff;
      out_pre_in    = out_pre_ff;
      out_mult_in   = out_mult_ff;
      out_freq_in   = out_freq_ff;
      out_upd_in    = out_upd_ff;
      valid_in      = valid_ff && !rsp_ready;
      unique case (ctrl.alu)
         ALU_STEP_FREQ: begin
            updated_in = allowed;
            if (allowed) begin
               if (op_ff) begin
                  freq_in = freq_ff + step_ext;
               end else begin
                  freq_in = (freq_ff > step_ext) ? freq_ff - step_ext : FREQ_MIN;
               end
            end
         end
         ALU_DIV_LOAD: begin
            band_in = band_of(freq_ff);
            quo_in  = band_dividend(band_of(freq_ff));
            rem_in  = '0;
            cnt_in  = DIV_STEPS;
         end
         ALU_DIV_STEP: begin
            rem_in = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], ge};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         ALU_SUB_OFF: begin
            acc_in = quo_ff[RELOAD_W-1:0] - RELOAD_W'(offset_ff);
         end
         ALU_TIMES3: begin
            // the lowest band is not scaled
            if (band_ff != BAND_SUB) begin
               acc_in = acc_ff + {acc_ff[RELOAD_W-2:0], 1'b0};
            end
         end
         ALU_RELOAD: begin
            reload_in = ~acc_ff;
            pre_in    = band_prescale(band_ff);
            mult_in   = (band_ff == BAND_SUB) ? MULT_SUB : MULT_NONE;
         end
         ALU_PUBLISH: begin
            if (publish) begin
               out_reload_in = reload_ff;
               out_pre_in    = pre_ff;
               out_mult_in   = mult_ff;
               out_freq_in   = freq_ff;
               out_upd_in    = updated_ff;
               valid_in      = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= OFFSET_RESET;
         freq_ff    <= FREQ_RESET;
         reload_ff  <= RELOAD_RESET;
         pre_ff     <= PRE_DIV1;
         mult_ff    <= MULT_NONE;
         updated_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         offset_ff  <= offset_in;
         freq_ff    <= freq_in;
         reload_ff  <= reload_in;
         pre_ff     <= pre_in;
         mult_ff    <= mult_in;
         updated_ff <= updated_in;
         valid_ff   <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      step_ff       <= step_in;
      band_ff       <= band_in;
      cnt_ff        <= cnt_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      acc_ff        <= acc_in;
      out_reload_ff <= out_reload_in;
      out_pre_ff    <= out_pre_in;
      out_mult_ff   <= out_mult_in;
      out_freq_ff   <= out_freq_in;
      out_upd_ff    <= out_upd_in;
   end

   // result beat
   assign rsp_valid             = valid_ff;
   assign rsp_reload_value      = out_reload_ff;
   assign rsp_prescale_code     = out_pre_ff;
   assign rsp_extend_multiplier = out_mult_ff;
   assign rsp_current_frequency = out_freq_ff;
   assign rsp_was_updated       = out_upd_ff;

   // checks
   a_freq_range: assert property (@(posedge clock) disable iff (reset)
      (freq_ff >= FREQ_MIN) && (freq_ff <= FREQ_MAX))
      else $error("frequency left its range");

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while one is in work");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (ctrl.alu == ALU_DIV_STEP) |-> (rem_ff < divisor))
      else $error("divider remainder not below divisor");

   a_mult_band: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_updated |->
         ((rsp_extend_multiplier == MULT_SUB) == (rsp_current_frequency <= EDGE_LOW)))
      else $error("multiplier does not match frequency band");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the tone frequency reload calculator: random steps, offsets and stalls
module testbench;
   import tfrc_pkg::*;

   // step directions
   localparam logic OP_LOWER = 1'b0;
   localparam logic OP_RAISE = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [STEP_W-1:0] step;
   } tone_step_type;

   typedef struct packed {
      logic [RELOAD_W-1:0] reload;
      logic [PRE_W-1:0]    prescale;
      logic [MULT_W-1:0]   multiplier;
      logic [FREQ_W-1:0]   frequency;
      logic                updated;
   } tone_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_en = 1'b0;
   logic [OFF_W-1:0]    csr_write_data = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_opcode = OP_LOWER;
   logic [STEP_W-1:0]   req_step_size = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [RELOAD_W-1:0] rsp_reload_value;
   logic [PRE_W-1:0]    rsp_prescale_code;
   logic [MULT_W-1:0]   rsp_extend_multiplier;
   logic [FREQ_W-1:0]   rsp_current_frequency;
   logic                rsp_was_updated;

   tone_frequency_reload_calculator u_top (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_en          (csr_write_en),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_step_size         (req_step_size),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_reload_value      (rsp_reload_value),
      .rsp_prescale_code     (rsp_prescale_code),
      .rsp_extend_multiplier (rsp_extend_multiplier),
      .rsp_current_frequency (rsp_current_frequency),
      .rsp_was_updated       (rsp_was_updated)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // steps waiting to be driven and settings waiting to come back
   tone_step_type   tone_steps_pending[$];
   tone_result_type tone_results_due[$];

   // predicted block state
   logic [FREQ_W-1:0]   model_freq     = FREQ_RESET;
   logic [RELOAD_W-1:0] model_reload   = RELOAD_RESET;
   logic [PRE_W-1:0]    model_prescale = PRE_DIV1;
   logic [MULT_W-1:0]   model_mult     = MULT_NONE;
   logic [OFF_W-1:0]    model_offset   = OFFSET_RESET;

   // handshakes seen at the last rising edge
   bit req_fire;
   bit rsp_fire;

   int req_gap;
   int rsp_gap;
   int calm_left;
   int errors;
   int beats_taken;
   int results_seen;
   int blocked_seen;
   int sub_band_seen;
   int offsets_used;

   // applies one step to the predicted state and returns the settings it reports
   function automatic tone_result_type predict_tone_step(input logic op,
                                                         input logic [STEP_W-1:0] step);
      tone_result_type r;
      int unsigned     f;
      int unsigned     dividend;
      int unsigned     count;
      logic            moved;
      moved = 1'b0;
      if (op == OP_LOWER) begin
         if (model_freq > FREQ_MIN) begin
            model_freq = (model_freq > step) ? model_freq - step : FREQ_MIN;
            moved = 1'b1;
         end
      end else if (model_freq < UPPER_FREQ_LIMIT) begin
         model_freq = model_freq + step;
         moved = 1'b1;
      end
      if (moved) begin
         f = model_freq;
         if (f > EDGE_TOP) begin
            dividend = 2000000;
            model_prescale = PRE_DIV1;
         end else if (f > EDGE_HIGH) begin
            dividend = 1000000;
            model_prescale = PRE_DIV2;
         end else if (f > EDGE_MID) begin
            dividend = 500000;
            model_prescale = PRE_DIV4;
         end else if (f > EDGE_LOW) begin
            dividend = 250000;
            model_prescale = PRE_DIV8;
         end else begin
            dividend = 62500;
            model_prescale = PRE_DIV8;
         end
         // zero frequency cannot occur, but divide by one if it did
         count = dividend / ((f == 0) ? 1 : f) - model_offset;
         if (f > EDGE_LOW) begin
            count = count * 3;
            model_mult = MULT_NONE;
         end else begin
            model_mult = MULT_SUB;
         end
         model_reload = 16'hFFFF - count[15:0];
      end
      r.reload     = model_reload;
      r.prescale   = model_prescale;
      r.multiplier = model_mult;
      r.frequency  = model_freq;
      r.updated    = moved;
      return r;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm_left > 0) return 0;
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic flag_field(input string field, input int unsigned want,
                             input int unsigned got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
   endtask

   // monitor: record accepted steps, check returned settings
   always @(posedge clock) begin
      tone_result_type want;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_fire = 1'b1;
            results_seen++;
            if (tone_results_due.size() == 0) begin
               $display("%0t: result beat with nothing expected, actual reload %0d freq %0d",
                        $time, rsp_reload_value, rsp_current_frequency);
               errors++;
            end else begin
               want = tone_results_due.pop_front();
               if (!want.updated) blocked_seen++;
               if (want.multiplier == MULT_SUB) sub_band_seen++;
               if (rsp_reload_value !== want.reload)
                  flag_field("reload_value", want.reload, rsp_reload_value);
               if (rsp_prescale_code !== want.prescale)
                  flag_field("prescale_code", want.prescale, rsp_prescale_code);
               if (rsp_extend_multiplier !== want.multiplier)
                  flag_field("extend_multiplier", want.multiplier, rsp_extend_multiplier);
               if (rsp_current_frequency !== want.frequency)
                  flag_field("current_frequency", want.frequency, rsp_current_frequency);
               if (rsp_was_updated !== want.updated)
                  flag_field("was_updated", want.updated, rsp_was_updated);
            end
         end
         if (req_valid && req_ready) begin
            req_fire = 1'b1;
            beats_taken++;
            tone_results_due.push_back(predict_tone_step(req_opcode, req_step_size));
         end
      end
   end

   // driver: feed pending steps, throttle both sides
   always @(negedge clock) begin
      logic          next_valid;
      tone_step_type beat;
      next_valid = req_valid;
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 999) == 0) calm_left = 300;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            next_valid = 1'b0;
            req_gap--;
         end else if (tone_steps_pending.size() != 0) begin
            beat = tone_steps_pending.pop_front();
            req_opcode <= beat.opcode;
            req_step_size <= beat.step;
            next_valid = 1'b1;
            req_gap = pick_gap();
         end else begin
            next_valid = 1'b0;
         end
      end
      req_valid <= next_valid;
      // result side back-pressure
      if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_fire || $urandom_range(0, 7) == 0) rsp_gap = pick_gap();
      end
   end

   // stimulus side copy of the frequency, used to steer the random walk
   int gen_freq = FREQ_RESET;

   task automatic queue_step(input logic op, input logic [STEP_W-1:0] step);
      tone_step_type beat;
      beat.opcode = op;
      beat.step = step;
      tone_steps_pending.push_back(beat);
      if (op == OP_LOWER) begin
         if (gen_freq > 1) gen_freq = (gen_freq > step) ? gen_freq - step : 1;
      end else if (gen_freq < UPPER_FREQ_LIMIT) begin
         gen_freq = gen_freq + step;
      end
   endtask

   // wait until every step is taken and answered, then let the block settle
   // checked at the rising edge, where the driven valid is already stable
   task automatic wait_quiet();
      do @(posedge clock);
      while (tone_steps_pending.size() != 0 || req_valid || tone_results_due.size() != 0);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_offset(input logic [OFF_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      model_offset = value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      offsets_used++;
   endtask

   initial begin
      logic [OFF_W-1:0]  offsets[5];
      logic              op;
      logic [STEP_W-1:0] step;
      bit                sweep_down;
      int                r;
      offsets[0] = 8'd255;
      offsets[1] = 8'd0;
      offsets[2] = 8'($urandom_range(1, 254));
      offsets[3] = 8'd128;
      offsets[4] = 8'($urandom_range(0, 255));
      sweep_down = 1'b1;
      offsets_used = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // raising at the limit is blocked, a zero step still recomputes
      queue_step(OP_RAISE, 8'd0);
      queue_step(OP_RAISE, 8'd255);
      queue_step(OP_LOWER, 8'd0);
      // walk down across every band edge
      queue_step(OP_LOWER, 8'd255);
      queue_step(OP_LOWER, 8'd255);
      queue_step(OP_LOWER, 8'd255);
      queue_step(OP_LOWER, 8'd134);
      queue_step(OP_LOWER, 8'd1);
      queue_step(OP_LOWER, 8'd39);
      queue_step(OP_LOWER, 8'd1);
      queue_step(OP_LOWER, 8'd29);
      queue_step(OP_LOWER, 8'd1);
      queue_step(OP_LOWER, 8'd9);
      queue_step(OP_LOWER, 8'd1);
      queue_step(OP_LOWER, 8'd19);
      // lowering at one is blocked, lowering past one saturates
      queue_step(OP_LOWER, 8'd5);
      queue_step(OP_RAISE, 8'd1);
      queue_step(OP_LOWER, 8'd255);
      // climb to just under the limit, then past it
      queue_step(OP_RAISE, 8'd255);
      queue_step(OP_RAISE, 8'd255);
      queue_step(OP_RAISE, 8'd255);
      queue_step(OP_RAISE, 8'd233);
      queue_step(OP_RAISE, 8'd255);
      queue_step(OP_RAISE, 8'd1);
      queue_step(OP_LOWER, 8'd0);
      wait_quiet();

      // random sweeps under several offsets
      foreach (offsets[p]) begin
         write_offset(offsets[p]);
         repeat (245) begin
            if ($urandom_range(0, 15) == 0) sweep_down = !sweep_down;
            if (gen_freq >= UPPER_FREQ_LIMIT && $urandom_range(0, 3) != 0)
               op = OP_LOWER;
            else if (gen_freq <= 1 && $urandom_range(0, 3) != 0)
               op = OP_RAISE;
            else if ($urandom_range(0, 4) != 0)
               op = sweep_down ? OP_LOWER : OP_RAISE;
            else
               op = sweep_down ? OP_RAISE : OP_LOWER;
            r = $urandom_range(0, 9);
            if (r == 0)
               step = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            else if (r <= 5)
               step = (gen_freq <= 120) ? 8'($urandom_range(0, 12))
                                        : 8'($urandom_range(0, 40));
            else
               step = 8'($urandom_range(0, 255));
            queue_step(op, step);
         end
         wait_quiet();
      end

      $display("covered %0d steps under %0d offset settings, %0d results checked",
               beats_taken, offsets_used, results_seen);
      $display("%0d were blocked steps, %0d landed in the lowest band",
               blocked_seen, sub_band_seen);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("%0t: timeout, %0d results still outstanding", $time, tone_results_due.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> sim.f
hdl/tfrc_pkg.sv
hdl/tfrc_useq.sv
hdl/tone_frequency_reload_calculator.sv
tb/testbench.sv
